// ===== rtl/core/qdil_pkg.sv =====
// ----------------------------------------------------------------------------
// qdil_pkg
// Types, register indexes and the A/B step table of the quadrature decoder.
// ----------------------------------------------------------------------------
package qdil_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int HOLD_WIDTH      = 16;
    localparam int OUT_WIDTH       = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_TICKS   = 2'd1;

    localparam logic [HOLD_WIDTH-1:0] HOLD_TICKS_RESET = 16'd120;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic pin_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] position_out;
        logic                        index_flag;
    } out_beat_t;

    typedef struct packed {
        logic                  index_enable;
        logic [HOLD_WIDTH-1:0] index_hold_ticks;
    } cfg_t;

    // sel = {new_b, new_a, old_b, old_a}
    function automatic logic signed [2:0] ab_step(input logic [3:0] sel);
        logic signed [2:0] step;
        begin
            case (sel)
                4'd1, 4'd7, 4'd8, 4'd14:  step = 3'sd1;
                4'd2, 4'd4, 4'd11, 4'd13: step = -3'sd1;
                4'd3, 4'd12:              step = 3'sd2;
                4'd6, 4'd9:               step = -3'sd2;
                default:                  step = 3'sd0;
            endcase
            return step;
        end
    endfunction

endpackage

// ===== rtl/core/qdil_count.sv =====
// ----------------------------------------------------------------------------
// qdil_count
// A/B edge decode and wrapping position counter.
// ----------------------------------------------------------------------------
module qdil_count
    import qdil_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  in_beat_t                      pins,
    output logic                          primed,
    output logic signed [COUNT_WIDTH-1:0] position_next
);

    logic                          primed_reg;
    logic [1:0]                    prev_ab_reg;
    logic signed [COUNT_WIDTH-1:0] position_reg;
    logic [1:0]                    new_ab;
    logic signed [2:0]             step;

    assign new_ab = {pins.pin_b, pins.pin_a};
    assign step   = ab_step({new_ab, prev_ab_reg});

    always_comb
    begin
        if (primed_reg)
        begin
            position_next = position_reg + COUNT_WIDTH'(step);
        end
        else
        begin
            position_next = position_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg   <= 1'b0;
            prev_ab_reg  <= 2'b00;
            position_reg <= '0;
        end
        else if (advance)
        begin
            primed_reg   <= 1'b1;
            prev_ab_reg  <= new_ab;
            position_reg <= position_next;
        end
    end

    assign primed = primed_reg;

endmodule

// ===== rtl/core/qdil_index.sv =====
// ----------------------------------------------------------------------------
// qdil_index
// Index edge detect, position latch and hold countdown.
// ----------------------------------------------------------------------------
module qdil_index
    import qdil_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          primed,
    input  logic                          pin_index,
    input  cfg_t                          cfg,
    input  logic signed [COUNT_WIDTH-1:0] position_next,
    output logic signed [COUNT_WIDTH-1:0] shown,
    output logic                          flag
);

    logic                          prev_index_reg;
    logic [HOLD_WIDTH-1:0]         hold_left_reg;
    logic [HOLD_WIDTH-1:0]         hold_left_next;
    logic signed [COUNT_WIDTH-1:0] latched_reg;
    logic signed [COUNT_WIDTH-1:0] latched_next;
    logic                          rising;

    assign rising = pin_index && !prev_index_reg;

    always_comb
    begin
        shown          = position_next;
        flag           = 1'b0;
        hold_left_next = hold_left_reg;
        latched_next   = latched_reg;
        if (primed)
        begin
            if (!cfg.index_enable)
            begin
                hold_left_next = '0;
            end
            else if (rising && hold_left_reg == '0)
            begin
                latched_next   = position_next;
                hold_left_next = cfg.index_hold_ticks;
                flag           = 1'b1;
            end
            else if (hold_left_reg != '0)
            begin
                hold_left_next = hold_left_reg - 1'b1;
                shown          = latched_reg;
                flag           = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_index_reg <= 1'b0;
            hold_left_reg  <= '0;
            latched_reg    <= '0;
        end
        else if (advance)
        begin
            prev_index_reg <= pin_index;
            hold_left_reg  <= hold_left_next;
            latched_reg    <= latched_next;
        end
    end

endmodule

// ===== rtl/core/quadrature_decoder_index_latch_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_index_latch_top
// Quadrature A/B decoder with wrapping count and index capture/hold.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one beat per sample of pins A, B and index.
//   out channel : one beat per input beat, the reported position and the
//                 index flag. Position is the live count, or the latched
//                 count while an index hold runs.
//   cfg channel : register writes (index 0 enable, index 1 hold ticks);
//                 always ready, writes to other indexes are dropped.
// A beat accepted at a clock edge is shown on out the next cycle. Throughput
// is one beat per cycle while out is not stalled, set by the single output
// register that follows the combinational decode/count/latch logic.
// The first beat after reset only primes the previous pin levels.
// Reset clears all counters, the hold and the config (hold ticks to 120).
// When out is stalled, in_ready drops until the held result is taken.
// ----------------------------------------------------------------------------
module quadrature_decoder_index_latch_top
    import qdil_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  in_beat_t                   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_beat_t                  out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t                          cfg_reg;
    logic                          advance;
    logic                          primed;
    logic signed [COUNT_WIDTH-1:0] position_next;
    logic signed [COUNT_WIDTH-1:0] shown;
    logic                          flag;
    logic                          out_valid_reg;
    out_beat_t                     out_data_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign advance   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_enable     <= 1'b0;
            cfg_reg.index_hold_ticks <= HOLD_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INDEX_ENABLE: cfg_reg.index_enable     <= cfg_data[0];
                CFG_HOLD_TICKS:   cfg_reg.index_hold_ticks <= cfg_data;
                default:          ;
            endcase
        end
    end

    qdil_count #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .pins         (in_data),
        .primed       (primed),
        .position_next(position_next)
    );

    qdil_index #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .primed       (primed),
        .pin_index    (in_data.pin_index),
        .cfg          (cfg_reg),
        .position_next(position_next),
        .shown        (shown),
        .flag         (flag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // sign-extend or truncate the count to the 32-bit result field
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.position_out <= OUT_WIDTH'(shown);
            out_data_reg.index_flag   <= flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
